>>> rtl/core/sls_pkg.sv
// Package with shared constants, types and tables for the Stanley lateral steering block.
`timescale 1ns / 1ps
package sls_pkg;
    localparam int unsigned MaxPointsDefault   = 64;
    localparam int unsigned CordicStepsDefault = 16;
    localparam int unsigned AngTableLen        = 24;

    localparam logic [1:0] CFG_GAIN  = 2'd0;
    localparam logic [1:0] CFG_MAXW  = 2'd1;
    localparam logic [1:0] CFG_LBASE = 2'd2;
    localparam logic [1:0] CFG_LPS   = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic signed [17:0] PiQ13    = 18'sd25736;
    localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
    localparam logic signed [35:0] PiQ30    = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] CordicKQ30 = 36'sd652032874;
    localparam logic signed [17:0] SwScale  = 18'sd110008;
    localparam logic signed [16:0] SpeedFloor = 17'sd128;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
    } t_point;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd843314857;
                5'd1:  r = 32'd497837829;
                5'd2:  r = 32'd263043837;
                5'd3:  r = 32'd133525159;
                5'd4:  r = 32'd67021687;
                5'd5:  r = 32'd33543516;
                5'd6:  r = 32'd16775850;
                5'd7:  r = 32'd8388437;
                5'd8:  r = 32'd4194283;
                5'd9:  r = 32'd2097149;
                5'd10: r = 32'd1048576;
                5'd11: r = 32'd524288;
                5'd12: r = 32'd262144;
                5'd13: r = 32'd131072;
                5'd14: r = 32'd65536;
                5'd15: r = 32'd32768;
                5'd16: r = 32'd16384;
                5'd17: r = 32'd8192;
                5'd18: r = 32'd4096;
                5'd19: r = 32'd2048;
                5'd20: r = 32'd1024;
                5'd21: r = 32'd512;
                5'd22: r = 32'd256;
                5'd23: r = 32'd128;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage

>>> rtl/core/stanley_lateral_steering.sv
// Top level of the Stanley lateral steering block with point store and CORDIC sequencer.
//
//  Channel  | Signals                                   | Dir | Word moved
//  ---------+-------------------------------------------+-----+---------------------------
//  input    | i_in_valid / o_in_ready, i_cmd .. i_emergency_stop | in | point load or tick
//  output   | o_out_valid / i_out_ready, o_steering_angle .. | out | steering result
//  config   | i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data | in | register write
//
// A load writes the point store and returns to idle; an emergency or hold tick puts its
// result into the output register at its accept. A tick that walks the store then runs the
// CORDIC rotations, whose number is CORDIC_STEPS capped at the table length; each point
// walked costs a store read, a difference, a squaring of each offset and a compare.
// Reset clears the control state and the registers but not the point store. A new word is
// taken only once the previous result has left the output register.
`timescale 1ns / 1ps
module stanley_lateral_steering #(
    parameter int unsigned MAX_POINTS   = sls_pkg::MaxPointsDefault,
    parameter int unsigned CORDIC_STEPS = sls_pkg::CordicStepsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [15:0] i_point_heading,
    input  logic               i_point_last,
    input  logic signed [31:0] i_ego_x,
    input  logic signed [31:0] i_ego_y,
    input  logic signed [15:0] i_ego_yaw,
    input  logic signed [15:0] i_ego_speed,
    input  logic               i_emergency_stop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_steering_angle,
    output logic               o_emergency_active,
    output logic [5:0]         o_target_slot,
    output logic               o_steer_updated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import sls_pkg::*;

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned NSTEP = (CORDIC_STEPS < AngTableLen) ? CORDIC_STEPS : AngTableLen;
    localparam logic [4:0] LastStep = 5'(NSTEP - 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD    = 5'd1;
    localparam logic [4:0] S_DIFF  = 5'd2;
    localparam logic [4:0] S_SQX   = 5'd3;
    localparam logic [4:0] S_SQY   = 5'd4;
    localparam logic [4:0] S_CMP   = 5'd5;
    localparam logic [4:0] S_PSI   = 5'd6;
    localparam logic [4:0] S_SC    = 5'd7;
    localparam logic [4:0] S_EM1   = 5'd8;
    localparam logic [4:0] S_EM2   = 5'd9;
    localparam logic [4:0] S_AT    = 5'd10;
    localparam logic [4:0] S_SW1   = 5'd11;
    localparam logic [4:0] S_SW2   = 5'd12;
    localparam logic [4:0] S_LDW   = 5'd13;
    localparam logic [4:0] S_PRE   = 5'd14;
    localparam logic [4:0] S_PRE2  = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    t_point r_mem [MAX_POINTS];
    t_point r_rd;

    logic [4:0]  r_state;
    logic [CW-1:0] r_count;
    logic        r_pvalid;
    logic signed [14:0] r_held;
    logic [15:0] r_gain;
    logic [13:0] r_maxw;
    logic [15:0] r_lbase;
    logic [7:0]  r_lps;

    logic signed [31:0] r_ex, r_ey;
    logic signed [15:0] r_yaw, r_spd;
    logic signed [24:0] r_L;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_slot;
    logic [32:0] r_ax, r_ay;
    logic [65:0] r_sq;
    logic [65:0] r_lsq;
    logic        r_quick;
    logic signed [32:0] r_dx, r_dy;
    logic signed [17:0] r_psi;
    logic signed [53:0] r_cx, r_cy;
    logic signed [37:0] r_cz;
    logic        r_neg;
    logic [4:0]  r_step;
    logic signed [17:0] r_c14, r_s14;
    logic signed [51:0] r_p1;
    logic signed [18:0] r_delta;
    logic signed [37:0] r_swp;
    logic [AW-1:0] r_wa;
    t_point r_wd;
    logic r_wen;
    logic r_ld_last;

    logic r_ov;
    logic signed [14:0] r_o_sw;
    logic r_o_em, r_o_upd;
    logic [5:0] r_o_slot;

    logic in_acc;
    assign o_in_ready = (r_state == S_IDLE) && !r_ov;
    assign in_acc = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_steering_angle = r_o_sw;
    assign o_emergency_active = r_o_em;
    assign o_target_slot = r_o_slot;
    assign o_steer_updated = r_o_upd;

    always_ff @(posedge i_clk) begin
        if (r_wen) begin
            r_mem[r_wa] <= r_wd;
        end
        r_rd <= r_mem[r_idx];
    end

    logic [5:0] slot6;
    assign slot6 = 6'(r_slot);

    logic signed [53:0] sh_x, sh_y;
    logic signed [37:0] at_e;
    assign sh_x = r_cx >>> r_step;
    assign sh_y = r_cy >>> r_step;
    assign at_e = {6'd0, atan_entry(r_step)};

    logic signed [35:0] z0;
    logic signed [17:0] psi_raw;
    logic signed [24:0] prod_l;
    logic signed [53:0] rx, ry;
    logic signed [18:0] sw_round;
    logic signed [15:0] lim_p, lim_n;
    assign z0 = 36'(r_yaw) <<< 17;
    assign psi_raw = 18'(r_rd.heading) - 18'(r_yaw);
    assign prod_l = 25'(signed'({1'b0, r_lps}) * r_spd);
    assign rx = r_cx + 54'sd32768;
    assign ry = r_cy + 54'sd32768;
    assign sw_round = 19'((r_swp + 38'sd32768) >>> 16);
    assign lim_p = signed'({2'b0, r_maxw});
    assign lim_n = -lim_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pvalid <= 1'b0;
            r_held   <= '0;
            r_gain   <= 16'd512;
            r_maxw   <= 14'd7200;
            r_lbase  <= 16'd5120;
            r_lps    <= 8'd77;
            r_ov     <= 1'b0;
            r_wen    <= 1'b0;
        end else begin
            r_wen <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN:  r_gain  <= i_cfg_data;
                    CFG_MAXW:  r_maxw  <= i_cfg_data[13:0];
                    CFG_LBASE: r_lbase <= i_cfg_data;
                    CFG_LPS:   r_lps   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ex <= i_ego_x; r_ey <= i_ego_y;
                        r_yaw <= i_ego_yaw; r_spd <= i_ego_speed;
                        if (i_cmd == CMD_LOAD) begin
                            r_wa <= AW'(i_point_index);
                            r_wd <= '{x: i_point_x, y: i_point_y, heading: i_point_heading};
                            r_ld_last <= i_point_last;
                            r_wen <= (32'(i_point_index) < MAX_POINTS);
                            r_state <= (32'(i_point_index) < MAX_POINTS) ? S_LDW : S_IDLE;
                        end else if (i_emergency_stop) begin
                            r_held <= '0;
                            r_o_sw <= '0; r_o_em <= 1'b1; r_o_slot <= '0; r_o_upd <= 1'b0;
                            r_ov <= 1'b1;
                        end else if (!r_pvalid || r_count == '0) begin
                            r_o_sw <= r_held; r_o_em <= 1'b0; r_o_slot <= '0;
                            r_o_upd <= 1'b0;
                            r_ov <= 1'b1;
                        end else begin
                            r_idx <= '0;
                            r_state <= S_PRE;
                        end
                    end
                end
                S_LDW: begin
                    if (r_ld_last) begin
                        r_count <= CW'({1'b0, r_wa}) + CW'(1);
                        r_pvalid <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_PRE: begin
                    r_L <= 25'(signed'({1'b0, r_lbase})) + (prod_l >>> 6);
                    r_state <= S_PRE2;
                end
                S_PRE2: begin
                    r_lsq <= 66'(r_L * r_L);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx <= 33'(r_rd.x) - 33'(r_ex);
                    r_dy <= 33'(r_rd.y) - 33'(r_ey);
                    r_ax <= (r_rd.x >= r_ex) ? 33'(33'(r_rd.x) - 33'(r_ex))
                                             : 33'(33'(r_ex) - 33'(r_rd.x));
                    r_ay <= (r_rd.y >= r_ey) ? 33'(33'(r_rd.y) - 33'(r_ey))
                                             : 33'(33'(r_ey) - 33'(r_rd.y));
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_quick <= (r_L <= 0) || ($signed({1'b0, r_ax}) >= 34'(r_L))
                            || ($signed({1'b0, r_ay}) >= 34'(r_L));
                    r_sq <= 66'(r_ax[24:0] * r_ax[24:0]);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sq <= r_sq + 66'(r_ay[24:0] * r_ay[24:0]);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_quick || r_sq >= r_lsq) begin
                        r_slot <= r_idx;
                        r_state <= S_PSI;
                    end else if (CW'({1'b0, r_idx}) + CW'(1) >= r_count) begin
                        r_slot <= r_idx;
                        r_state <= S_PSI;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_PSI: begin
                    if (psi_raw > PiQ13) r_psi <= psi_raw - TwoPiQ13;
                    else if (psi_raw < -PiQ13) r_psi <= psi_raw + TwoPiQ13;
                    else r_psi <= psi_raw;
                    r_cx <= 54'(CordicKQ30);
                    r_cy <= '0;
                    if (z0 > HalfPiQ30) begin
                        r_cz <= 38'(z0 - PiQ30); r_neg <= 1'b1;
                    end else if (z0 < -HalfPiQ30) begin
                        r_cz <= 38'(z0 + PiQ30); r_neg <= 1'b1;
                    end else begin
                        r_cz <= 38'(z0); r_neg <= 1'b0;
                    end
                    r_step <= '0;
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - sh_y; r_cy <= r_cy + sh_x; r_cz <= r_cz - at_e;
                    end else begin
                        r_cx <= r_cx + sh_y; r_cy <= r_cy - sh_x; r_cz <= r_cz + at_e;
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == LastStep) r_state <= S_EM1;
                end
                S_EM1: begin
                    if (r_neg) begin
                        r_c14 <= 18'((-r_cx + 54'sd32768) >>> 16);
                        r_s14 <= 18'((-r_cy + 54'sd32768) >>> 16);
                    end else begin
                        r_c14 <= 18'(rx >>> 16);
                        r_s14 <= 18'(ry >>> 16);
                    end
                    r_state <= S_EM2;
                end
                S_EM2: begin
                    r_p1 <= 52'(r_dy * r_c14) - 52'(r_dx * r_s14);
                    r_cz <= '0;
                    r_step <= 5'd31;
                    r_state <= S_AT;
                end
                S_AT: begin
                    if (r_step == 5'd31) begin
                        r_cx <= 54'(((r_spd < SpeedFloor) ? SpeedFloor : 17'(r_spd)) * 1024);
                        r_cy <= 54'(signed'({1'b0, r_gain}) * 35'(r_p1 >>> 14));
                        r_step <= '0;
                    end else begin
                        if (r_cy > 0) begin
                            r_cx <= r_cx + sh_y; r_cy <= r_cy - sh_x; r_cz <= r_cz + at_e;
                        end else begin
                            r_cx <= r_cx - sh_y; r_cy <= r_cy + sh_x; r_cz <= r_cz - at_e;
                        end
                        r_step <= r_step + 5'd1;
                        if (r_step == LastStep) r_state <= S_SW1;
                    end
                end
                S_SW1: begin
                    r_delta <= 19'(r_psi) + 19'((r_cz + 38'sd65536) >>> 17);
                    r_state <= S_SW2;
                end
                S_SW2: begin
                    r_swp <= 38'(r_delta * SwScale);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (sw_round > 19'(lim_p)) begin
                        r_o_sw <= 15'(lim_p); r_held <= 15'(lim_p);
                    end else if (sw_round < 19'(lim_n)) begin
                        r_o_sw <= 15'(lim_n); r_held <= 15'(lim_n);
                    end else begin
                        r_o_sw <= 15'(sw_round); r_held <= 15'(sw_round);
                    end
                    r_o_em <= 1'b0;
                    r_o_upd <= 1'b1;
                    r_o_slot <= slot6;
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted twice in a row");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_emergency_active) |-> (o_steering_angle == 15'sd0 && !o_steer_updated))
        else $error("emergency result carries steering");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_steer_updated) |-> (32'(o_target_slot) < MAX_POINTS))
        else $error("target slot out of range");
endmodule

>>> tb/sv/stanley_lateral_steering_chk.sv
// Checker that tracks the steering block's channels, predicts each result and compares it.
`timescale 1ns / 1ps
module stanley_lateral_steering_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [15:0] i_point_heading,
    input  logic               i_point_last,
    input  logic signed [31:0] i_ego_x,
    input  logic signed [31:0] i_ego_y,
    input  logic signed [15:0] i_ego_yaw,
    input  logic signed [15:0] i_ego_speed,
    input  logic               i_emergency_stop,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [14:0] i_steering_angle,
    input  logic               i_emergency_active,
    input  logic [5:0]         i_target_slot,
    input  logic               i_steer_updated,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    import sls_pkg::*;

    localparam int     Steps     = 16;
    localparam longint HalfPi30  = 64'sd1686629713;
    localparam longint Pi30      = 64'sd3373259426;
    localparam longint GainK30   = 64'sd652032874;
    localparam longint Pi13      = 64'sd25736;
    localparam longint TwoPi13   = 64'sd51472;
    localparam longint DegScale  = 64'sd110008;
    localparam longint MinSpeed  = 64'sd128;
    localparam longint AtanQ30 [0:15] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687, 64'sd33543516, 64'sd16775850, 64'sd8388437,
        64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
        64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768
    };

    typedef struct packed {
        logic [14:0] steer;
        logic        emerg;
        logic [5:0]  slot;
        logic        upd;
    } t_steer_word;

    logic signed [31:0] path_xs [64];
    logic signed [31:0] path_ys [64];
    logic signed [15:0] path_hd [64];
    int unsigned        n_points;
    bit                 have_path;
    logic signed [14:0] last_steer;
    logic [15:0]        gain;
    logic [13:0]        max_wheel;
    logic [15:0]        la_base;
    logic [7:0]         la_per_speed;
    t_steer_word        expected_steer [$];

    assign o_pending = expected_steer.size();

    function automatic bit beyond_lookahead(input longint dx, input longint dy, input longint la);
        longint ax;
        longint ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (la <= 0 || ax >= la || ay >= la) return 1'b1;
        return (ax * ax + ay * ay >= la * la);
    endfunction

    function automatic void yaw_sincos(input longint yaw, output longint c14, output longint s14);
        longint z;
        longint x;
        longint y;
        longint xn;
        bit     flip;
        z = yaw * 131072;
        x = GainK30;
        y = 0;
        flip = 1'b0;
        if (z > HalfPi30) begin
            z -= Pi30;
            flip = 1'b1;
        end else if (z < -HalfPi30) begin
            z += Pi30;
            flip = 1'b1;
        end
        for (int i = 0; i < Steps; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= AtanQ30[i];
            end else begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += AtanQ30[i];
            end
            x = xn;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c14 = (x + 32768) >>> 16;
        s14 = (y + 32768) >>> 16;
    endfunction

    function automatic longint atan_ratio(input longint x0, input longint y0);
        longint x;
        longint y;
        longint z;
        longint xn;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < Steps; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += AtanQ30[i];
            end else begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= AtanQ30[i];
            end
            x = xn;
        end
        return (z + 65536) >>> 17;
    endfunction

    function automatic t_steer_word steering_for_tick();
        t_steer_word r;
        longint ex, ey, yaw, spd, la, dx, dy, c14, s14, xte, psi, sw, lim, sp;
        int     slot;
        ex = i_ego_x;
        ey = i_ego_y;
        yaw = i_ego_yaw;
        spd = i_ego_speed;
        la = longint'(la_base) + ((longint'(la_per_speed) * spd) >>> 6);
        slot = n_points - 1;
        for (int i = 0; i < n_points; i++) begin
            if (beyond_lookahead(longint'(path_xs[i]) - ex, longint'(path_ys[i]) - ey, la)) begin
                slot = i;
                break;
            end
        end
        psi = longint'(path_hd[slot]) - yaw;
        while (psi > Pi13) psi -= TwoPi13;
        while (psi < -Pi13) psi += TwoPi13;
        dx = longint'(path_xs[slot]) - ex;
        dy = longint'(path_ys[slot]) - ey;
        yaw_sincos(yaw, c14, s14);
        xte = (dy * c14 - dx * s14) >>> 14;
        sp = (spd < MinSpeed) ? MinSpeed : spd;
        sw = ((psi + atan_ratio(sp * 1024, longint'(gain) * xte)) * DegScale + 32768) >>> 16;
        lim = longint'(max_wheel);
        if (sw > lim) sw = lim;
        if (sw < -lim) sw = -lim;
        r.steer = sw[14:0];
        r.emerg = 1'b0;
        r.slot = slot[5:0];
        r.upd = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_steer_word exp_w;
        if (!i_rst_n) begin
            n_points <= 0;
            have_path <= 1'b0;
            last_steer <= '0;
            gain <= 16'd512;
            max_wheel <= 14'd7200;
            la_base <= 16'd5120;
            la_per_speed <= 8'd77;
            o_errors <= 0;
            expected_steer.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_steer.size() == 0) begin
                    $display("%0t: unexpected steering word, actual %h/%b/%0d/%b", $time,
                             i_steering_angle, i_emergency_active, i_target_slot,
                             i_steer_updated);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = expected_steer.pop_front();
                    if (exp_w.steer !== i_steering_angle || exp_w.emerg !== i_emergency_active
                        || exp_w.slot !== i_target_slot || exp_w.upd !== i_steer_updated) begin
                        $display({"%0t: steering mismatch, expected angle %0d emerg %b",
                                  " slot %0d upd %b, actual angle %0d emerg %b slot %0d upd %b"},
                                 $time, $signed(exp_w.steer), exp_w.emerg, exp_w.slot,
                                 exp_w.upd, i_steering_angle, i_emergency_active,
                                 i_target_slot, i_steer_updated);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN:  gain <= i_cfg_data;
                    CFG_MAXW:  max_wheel <= i_cfg_data[13:0];
                    CFG_LBASE: la_base <= i_cfg_data;
                    CFG_LPS:   la_per_speed <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_LOAD) begin
                    path_xs[i_point_index] <= i_point_x;
                    path_ys[i_point_index] <= i_point_y;
                    path_hd[i_point_index] <= i_point_heading;
                    if (i_point_last) begin
                        n_points <= i_point_index + 1;
                        have_path <= 1'b1;
                    end
                end else if (i_emergency_stop) begin
                    last_steer <= '0;
                    expected_steer.push_back('{steer: '0, emerg: 1'b1, slot: '0, upd: 1'b0});
                end else if (!have_path || n_points == 0) begin
                    expected_steer.push_back('{steer: last_steer, emerg: 1'b0, slot: '0,
                                              upd: 1'b0});
                end else begin
                    exp_w = steering_for_tick();
                    last_steer <= exp_w.steer;
                    expected_steer.push_back(exp_w);
                end
            end
        end
    end
endmodule

>>> tb/sv/stanley_lateral_steering_tb.sv
// Testbench top that drives point loads, control ticks and register writes into the block.
`timescale 1ns / 1ps
module stanley_lateral_steering_tb;
    import sls_pkg::*;

    localparam int IdleLimit  = 20000;
    localparam int DrainWait  = 400;
    localparam int TargetWords = 950;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cmd;
    logic [5:0]         i_point_index;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [15:0] i_point_heading;
    logic               i_point_last;
    logic signed [31:0] i_ego_x;
    logic signed [31:0] i_ego_y;
    logic signed [15:0] i_ego_yaw;
    logic signed [15:0] i_ego_speed;
    logic               i_emergency_stop;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [14:0] o_steering_angle;
    logic               o_emergency_active;
    logic [5:0]         o_target_slot;
    logic               o_steer_updated;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    int                 out_stall;
    bit                 no_idle;
    int                 words_sent;
    int                 filled;
    logic signed [31:0] cx;
    logic signed [31:0] cy;

    stanley_lateral_steering u_top (.*);

    stanley_lateral_steering_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_cmd(i_cmd),
        .i_point_index(i_point_index), .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_point_heading(i_point_heading), .i_point_last(i_point_last),
        .i_ego_x(i_ego_x), .i_ego_y(i_ego_y), .i_ego_yaw(i_ego_yaw),
        .i_ego_speed(i_ego_speed), .i_emergency_stop(i_emergency_stop),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_steering_angle(o_steering_angle), .i_emergency_active(o_emergency_active),
        .i_target_slot(o_target_slot), .i_steer_updated(o_steer_updated),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall <= 0;
        end else if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            out_stall <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("[stanley_lateral_steering] ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [5:0] idx, input logic [31:0] px,
                             input logic [31:0] py, input logic [15:0] ph, input logic last,
                             input logic [31:0] ex, input logic [31:0] ey,
                             input logic [15:0] yaw, input logic [15:0] spd,
                             input logic estop);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd <= cmd;
        i_point_index <= idx;
        i_point_x <= px;
        i_point_y <= py;
        i_point_heading <= ph;
        i_point_last <= last;
        i_ego_x <= ex;
        i_ego_y <= ey;
        i_ego_yaw <= yaw;
        i_ego_speed <= spd;
        i_emergency_stop <= estop;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    task automatic load_point(input logic [5:0] idx, input logic [31:0] px,
                              input logic [31:0] py, input logic [15:0] ph,
                              input logic last);
        send_word(CMD_LOAD, idx, px, py, ph, last, $urandom, $urandom, 16'($urandom),
                  16'($urandom), 1'($urandom_range(0, 1)));
        if (idx == filled && filled < 64) filled++;
    endtask

    task automatic tick(input logic [31:0] ex, input logic [31:0] ey, input logic [15:0] yaw,
                        input logic [15:0] spd, input logic estop);
        send_word(CMD_TICK, 6'($urandom), $urandom, $urandom, 16'($urandom),
                  1'($urandom_range(0, 1)), ex, ey, yaw, spd, estop);
    endtask

    // Loads cause no word back, so the block may still be busy when the queue is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        int gap;
        gap = gap_len();
        repeat (gap) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] near(input logic signed [31:0] c, input int span);
        return c + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] pick_speed();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 8000));
        if (r < 9) return 16'(-$signed($urandom_range(0, 2000)));
        return 16'($urandom);
    endfunction

    initial begin
        int phase;
        int n;
        int ticks;
        int idx;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd <= CMD_LOAD;
        i_point_index <= '0;
        i_point_x <= '0;
        i_point_y <= '0;
        i_point_heading <= '0;
        i_point_last <= 1'b0;
        i_ego_x <= '0;
        i_ego_y <= '0;
        i_ego_yaw <= '0;
        i_ego_speed <= '0;
        i_emergency_stop <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GAIN;
        i_cfg_data <= '0;
        no_idle = 1'b0;
        words_sent = 0;
        filled = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tick(0, 0, 0, 0, 1'b0);
        tick(0, 0, 0, 0, 1'b1);
        load_point(0, 32'h7fffffff, 32'h80000000, 16'sd32767, 1'b0);
        load_point(1, 32'h80000000, 32'h7fffffff, -16'sd32768, 1'b0);
        load_point(2, 0, 0, 0, 1'b0);
        load_point(3, 5000, 100, 16'sd1000, 1'b1);
        tick(0, 0, 0, 0, 1'b0);
        tick(0, 0, 16'sd32767, 16'sd32767, 1'b0);
        tick(0, 0, -16'sd32768, -16'sd32768, 1'b0);
        tick(32'h7fffffff, 32'h80000000, 16'sd25736, 16'sd128, 1'b0);
        tick(32'h80000000, 32'h7fffffff, -16'sd25736, 16'sd127, 1'b0);
        tick(1000, -1000, 0, 16'sd256, 1'b1);
        tick(4000, 50, 16'sd12868, 16'sd2560, 1'b0);
        load_point(0, 5200, 0, 0, 1'b1);
        tick(0, 0, 0, 16'sd1000, 1'b0);
        tick(0, 10, 0, 0, 1'b0);

        phase = 0;
        while (words_sent < TargetWords) begin
            wait_idle();
            case (phase % 5)
                0: ;
                1: begin
                    write_reg(CFG_GAIN, 16'd0);
                    write_reg(CFG_MAXW, 16'd0);
                    write_reg(CFG_LBASE, 16'd0);
                    write_reg(CFG_LPS, 16'd0);
                end
                2: begin
                    write_reg(CFG_GAIN, 16'hffff);
                    write_reg(CFG_MAXW, 16'h3fff);
                    write_reg(CFG_LBASE, 16'hffff);
                    write_reg(CFG_LPS, 16'h00ff);
                end
                default: begin
                    write_reg(CFG_GAIN, 16'($urandom_range(0, 4096)));
                    write_reg(CFG_MAXW, 16'($urandom_range(0, 16383)));
                    write_reg(CFG_LBASE, 16'($urandom_range(0, 30000)));
                    write_reg(CFG_LPS, 16'($urandom_range(0, 255)));
                end
            endcase
            no_idle = ($urandom_range(0, 5) == 0);
            cx = ($urandom_range(0, 7) == 0) ? $urandom : near(0, 1000000);
            cy = ($urandom_range(0, 7) == 0) ? $urandom : near(0, 1000000);
            n = ($urandom_range(0, 11) == 0) ? 64 : $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                load_point(6'(i), near(cx, 40000), near(cy, 40000), 16'($urandom), i == n - 1);
            end
            ticks = $urandom_range(4, 14);
            for (int t = 0; t < ticks; t++) begin
                if ($urandom_range(0, 9) == 0) begin
                    idx = $urandom_range(0, 63);
                    load_point(6'(idx), near(cx, 40000), near(cy, 40000), 16'($urandom),
                               idx < filled && $urandom_range(0, 1) == 1);
                end
                if ($urandom_range(0, 15) == 0)
                    tick($urandom, $urandom, 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
                else
                    tick(near(cx, 30000), near(cy, 30000), 16'($urandom), pick_speed(),
                         $urandom_range(0, 19) == 0);
            end
            phase++;
        end
        wait_idle();
        if (errors == 0) begin
            $display("[stanley_lateral_steering] OK");
        end else begin
            $display("[stanley_lateral_steering] ERROR");
        end
        $finish;
    end
endmodule
